>>> rtl/core/fpba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpba_pkg;

  localparam int BLOCK_SLOTS = 16;
  localparam int SLOT_BITS   = $clog2(BLOCK_SLOTS);
  localparam int ADDR_BITS   = 16;
  localparam int SIZE_BITS   = 16;
  localparam int PID_BITS    = 8;

  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 40;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  // Fit modes.
  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;
  localparam logic [1:0] MODE_NEXT  = 2'd3;

  // Commands.
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_GRANTED = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_ADDED   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_SLACK = 8'd1;

  localparam logic [SIZE_BITS-1:0] SLACK_RESET = 16'd5;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [SIZE_BITS-1:0] size;
  } fpba_blk_t;

endpackage

`default_nettype wire

>>> rtl/core/fpba_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module fpba_cmp import fpba_pkg::*; (
  input  wire logic [1:0]           mode,
  input  wire logic [ADDR_BITS-1:0] rover,
  input  wire fpba_blk_t            cand,
  input  wire fpba_blk_t            best,
  output logic                      cand_better
);

  logic cand_up;
  logic best_up;

  assign cand_up = (cand.addr >= rover);
  assign best_up = (best.addr >= rover);

  // Size decides in best and worst fit; in next fit, blocks at or above the
  // rover win over those below it. Everything else falls back to address.
  always_comb begin
    if (mode == MODE_BEST && cand.size != best.size) begin
      cand_better = (cand.size < best.size);
    end else if (mode == MODE_WORST && cand.size != best.size) begin
      cand_better = (cand.size > best.size);
    end else if (mode == MODE_NEXT && cand_up != best_up) begin
      cand_better = cand_up;
    end else begin
      cand_better = (cand.addr < best.addr);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fit_policy_block_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// An allocate scans the table one slot per cycle through the shared compare unit, then
// commits; its result is registered, as is an add's. A new request is taken only after
// the last one has been committed or added, and a commit or add waits while an earlier
// result still waits on out_tready.
// Reset (synchronous, rst_n low) empties the table, clears the rover and loads
// fit mode 0 and a split slack of 5. No clearing pass is needed.

module fit_policy_block_allocator_unit import fpba_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: process_id [7:0], block_start [23:8], request_size [39:24]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: cmd [0]
  input  wire logic                  in_tuser,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // out_tdata: owner_id [7:0], granted_address [23:8], granted_size [39:24]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // out_tuser: status [1:0]
  output logic [1:0]                 out_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  localparam logic [1:0] S_ADD    = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [1:0]            fit_mode_r;
  logic [SIZE_BITS-1:0]  slack_r;
  logic [ADDR_BITS-1:0]  rover_r;
  logic [BLOCK_SLOTS-1:0] valid_r;
  logic [ADDR_BITS-1:0]  free_addr_r [BLOCK_SLOTS];
  logic [SIZE_BITS-1:0]  free_size_r [BLOCK_SLOTS];

  logic [PID_BITS-1:0]   pid_r;
  logic [ADDR_BITS-1:0]  start_r;
  logic [SIZE_BITS-1:0]  req_r;
  logic [SLOT_BITS-1:0]  idx_r;
  logic                  found_r;
  logic [SLOT_BITS-1:0]  best_idx_r;
  fpba_blk_t             best_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]            out_user_r;

  fpba_blk_t             cand;
  logic                  cand_better;
  logic                  cand_fit;
  logic                  take;
  logic                  accept;
  logic                  out_free;
  logic                  last_slot;

  logic [SLOT_BITS-1:0]  free_idx;
  logic                  any_free;
  logic [SIZE_BITS-1:0]  left;
  logic                  split;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign last_slot = (idx_r == SLOT_BITS'(BLOCK_SLOTS - 1));

  assign cand.addr = free_addr_r[idx_r];
  assign cand.size = free_size_r[idx_r];
  assign cand_fit  = valid_r[idx_r] && (cand.size >= req_r);
  assign take      = cand_fit && (!found_r || cand_better);

  fpba_cmp u_cmp (
    .mode        (fit_mode_r),
    .rover       (rover_r),
    .cand        (cand),
    .best        (best_r),
    .cand_better (cand_better)
  );

  // Lowest empty slot for an add.
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = BLOCK_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = SLOT_BITS'(i);
        any_free = 1'b1;
      end
    end
  end

  assign left  = best_r.size - req_r;
  assign split = (left > slack_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_tuser == CMD_ALLOC) ? S_SCAN : S_ADD;
        end
      end
      S_SCAN: begin
        if (last_slot) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_ADD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fit_mode_r  <= MODE_FIRST;
      slack_r     <= SLACK_RESET;
      rover_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FIT_MODE) begin
          fit_mode_r <= cfg_data[1:0];
        end else if (cfg_index == CFG_SPLIT_SLACK) begin
          slack_r <= cfg_data;
        end
      end
      if (accept) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        idx_r <= idx_r + 1'b1;
        if (take) begin
          found_r <= 1'b1;
        end
      end
      if (state_r == S_ADD && out_free && any_free) begin
        valid_r[free_idx] <= 1'b1;
      end
      if (state_r == S_COMMIT && out_free && found_r) begin
        if (!split) begin
          valid_r[best_idx_r] <= 1'b0;
        end
        if (fit_mode_r == MODE_NEXT) begin
          rover_r <= split ? (best_r.addr + req_r) : (best_r.addr + best_r.size);
        end
      end
      if ((state_r == S_COMMIT || state_r == S_ADD) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and table contents.
  always_ff @(posedge clk) begin
    if (accept) begin
      pid_r   <= in_tdata[7:0];
      start_r <= in_tdata[23:8];
      req_r   <= in_tdata[39:24];
    end
    if (state_r == S_SCAN && take) begin
      best_idx_r <= idx_r;
      best_r     <= cand;
    end
    if (state_r == S_ADD && out_free) begin
      if (any_free) begin
        free_addr_r[free_idx] <= start_r;
        free_size_r[free_idx] <= req_r;
        out_user_r            <= ST_ADDED;
      end else begin
        out_user_r <= ST_FULL;
      end
      out_data_r <= {{SIZE_BITS{1'b0}}, {ADDR_BITS{1'b0}}, pid_r};
    end
    if (state_r == S_COMMIT && out_free) begin
      if (found_r) begin
        if (split) begin
          free_addr_r[best_idx_r] <= best_r.addr + req_r;
          free_size_r[best_idx_r] <= left;
          out_data_r              <= {req_r, best_r.addr, pid_r};
        end else begin
          out_data_r <= {best_r.size, best_r.addr, pid_r};
        end
        out_user_r <= ST_GRANTED;
      end else begin
        out_data_r <= {{SIZE_BITS{1'b0}}, {ADDR_BITS{1'b0}}, pid_r};
        out_user_r <= ST_NO_FIT;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // A failed or add transaction never reports an address or size.
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_GRANTED |-> out_tdata[39:8] == '0)
    else $error("non-grant result carries address or size");

  // The table grows or shrinks by at most one slot per cycle.
  a_valid_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> $countones(valid_r) <= $past($countones(valid_r)) + 1 &&
              $countones(valid_r) + 1 >= $past($countones(valid_r)))
    else $error("slot table changed by more than one entry");

  // The rover only moves in next-fit mode.
  a_rover_mode: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && fit_mode_r != MODE_NEXT |=> $stable(rover_r))
    else $error("rover moved outside next-fit mode");

  // Nothing is accepted in the cycle after an acceptance.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("second item accepted while one is in work");

  // The table only changes while a commit or add is being retired.
  a_table_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && (state_r == S_IDLE || state_r == S_SCAN) |=> $stable(valid_r))
    else $error("slot table changed outside commit");

endmodule

`default_nettype wire
